/* design/stbs_pkg.sv */
// Shared constants and types for the sorted table binary search block.
// Used by the channel interfaces, the search engine and the top level.
package stbs_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	// Search bounds run from -1 up to the count, so they need a sign bit and one spare bit.
	localparam int BOUND_W     = ADDR_W + 2;

	// Fixed field widths.
	localparam int KEY_W = 32;
	localparam int POS_W = 8;
	localparam int CNT_W = 9;

	// Command codes.
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// Access request from the engine to the key memory.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [KEY_W-1:0]  wdata;
	} ram_req_t;

endpackage

/* design/stbs_if.sv */
// Valid/ready channel interfaces for command beats and result beats.
// Depends on stbs_pkg for the field widths.
interface stbs_in_if;
	logic                      valid;
	logic                      ready;
	logic                      command;
	logic [stbs_pkg::POS_W-1:0] position;
	logic [stbs_pkg::KEY_W-1:0] key;

	modport source (output valid, output command, output position, output key, input ready);
	modport sink   (input valid, input command, input position, input key, output ready);
endinterface

interface stbs_out_if;
	logic                      valid;
	logic                      ready;
	logic                      found;
	logic [stbs_pkg::POS_W-1:0] match_position;

	modport source (output valid, output found, output match_position, input ready);
	modport sink   (input valid, input found, input match_position, output ready);
endinterface

/* design/stbs_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write when enabled, read the addressed entry every cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* design/stbs_engine.sv */
// Search sequencer: takes command beats, drives the key memory one probe per cycle
// and holds the result beat in an output register. Depends on stbs_pkg and stbs_if.
module stbs_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [stbs_pkg::BOUND_W-1:0]  count,
	stbs_in_if.sink                       in_ch,
	stbs_out_if.source                    out_ch,
	output stbs_pkg::ram_req_t            ram_req,
	input  logic [stbs_pkg::KEY_W-1:0]    ram_rdata
);

	localparam int BW = stbs_pkg::BOUND_W;
	localparam int AW = stbs_pkg::ADDR_W;
	localparam int PW = stbs_pkg::POS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RESP
	} state_t;

	state_t                    state_q;
	logic signed [BW-1:0]      lo_q;
	logic signed [BW-1:0]      hi_q;
	logic [AW-1:0]             mid_q;
	logic [stbs_pkg::KEY_W-1:0] key_q;
	logic                      res_found_q;
	logic [PW-1:0]             res_pos_q;
	logic                      out_valid_q;
	logic                      out_found_q;
	logic [PW-1:0]             out_pos_q;

	logic                      accept;
	logic                      is_lookup;
	logic                      is_write;
	logic signed [BW-1:0]      hi_init;
	logic [BW-1:0]             hi_init_u;
	logic [AW-1:0]             mid_init;
	logic signed [BW-1:0]      mid_ext;
	logic                      hit;
	logic                      less;
	logic signed [BW-1:0]      nlo;
	logic signed [BW-1:0]      nhi;
	logic [BW-1:0]             nsum;
	logic [AW-1:0]             nmid;
	logic                      go_on;
	logic                      fin_valid;
	logic                      fin_found;
	logic [PW-1:0]             fin_pos;
	logic                      slot_free;

	// Input handshake: one item at a time.
	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_lookup   = accept && (in_ch.command == stbs_pkg::CMD_LOOKUP);
	assign is_write    = accept && (in_ch.command == stbs_pkg::CMD_WRITE)
		&& ({{(32 - PW){1'b0}}, in_ch.position} < 32'(stbs_pkg::TABLE_DEPTH));

	// Initial bounds of a lookup: low is zero, high is count minus one.
	assign hi_init   = $signed(count - BW'(1));
	assign hi_init_u = hi_init;
	assign mid_init  = AW'(hi_init_u >> 1);

	// One probe: compare the entry read at mid and narrow the bounds.
	assign mid_ext = BW'(mid_q);
	assign hit     = (ram_rdata == key_q);
	assign less    = ($signed(ram_rdata) < $signed(key_q));
	assign nlo     = less ? (mid_ext + BW'(1)) : lo_q;
	assign nhi     = less ? hi_q : (mid_ext - BW'(1));
	assign nsum    = nlo + nhi;
	assign nmid    = AW'(nsum >> 1);
	assign go_on   = !hit && (nlo <= nhi);

	// A result is ready when a lookup of an empty table arrives or a probe ends the search.
	always_comb begin
		fin_valid = 1'b0;
		fin_found = 1'b0;
		fin_pos   = '0;
		case (state_q)
			ST_IDLE: begin
				fin_valid = is_lookup && hi_init[BW-1];
			end
			ST_SEARCH: begin
				fin_valid = !go_on;
				fin_found = hit;
				fin_pos   = hit ? PW'(mid_q) : '0;
			end
			default: begin
				fin_valid = 1'b0;
			end
		endcase
	end

	assign slot_free = !out_valid_q || out_ch.ready;

	// Memory request: write on a write beat, otherwise read the next probe.
	always_comb begin
		ram_req.we    = is_write;
		ram_req.wdata = in_ch.key;
		ram_req.addr  = mid_q;
		case (state_q)
			ST_IDLE: begin
				ram_req.addr = is_write ? AW'(in_ch.position) : mid_init;
			end
			ST_SEARCH: begin
				ram_req.addr = nmid;
			end
			default: begin
				ram_req.addr = mid_q;
			end
		endcase
	end

	// Sequencer state, bounds and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (is_lookup) begin
						key_q <= in_ch.key;
						lo_q  <= '0;
						hi_q  <= hi_init;
						mid_q <= mid_init;
						if (!hi_init[BW-1]) begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					lo_q  <= nlo;
					hi_q  <= nhi;
					mid_q <= nmid;
				end
				ST_RESP: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_found_q <= res_found_q;
						out_pos_q   <= res_pos_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Hand a finished result to the output register, or park it.
			if (fin_valid) begin
				if (slot_free) begin
					out_valid_q <= 1'b1;
					out_found_q <= fin_found;
					out_pos_q   <= fin_pos;
					state_q     <= ST_IDLE;
				end else begin
					res_found_q <= fin_found;
					res_pos_q   <= fin_pos;
					state_q     <= ST_RESP;
				end
			end
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.found          = out_found_q;
	assign out_ch.match_position = out_pos_q;

endmodule

/* design/sorted_table_binary_search.sv */
// Sorted table binary search.
// Channels: in_ch carries command beats (command, position, key); out_ch carries
// result beats (found, match_position). Both are valid/ready; a beat moves when
// valid and ready are high at a rising clock edge. cfg_wr_en/cfg_wr_data set the
// number of entries searched; write it only while the block is idle.
// A write beat stores its key and produces no result; ready stays high.
// A lookup beat is accepted in the idle state and then probes the key memory in the
// search state: up to ceil(log2(count + 1)) probes, 9 for a full 256-entry table.
// The result is registered in the output register, or parked when the receiver
// stalls; a lookup with a count of zero skips the search state. The
// single-port key memory, with its registered read, sets the rate of one probe per cycle.
// in_ch.ready is low while a lookup is in progress. When the receiver stalls, the
// output register holds its beat and one more result can be parked inside; after
// that, in_ch.ready stays low until out_ch drains.
// Reset clears the entry count to zero and empties the output register. The key
// memory is not cleared; entries read before being written are undefined.
// Depends on stbs_pkg, stbs_if, stbs_ram and stbs_engine.
module sorted_table_binary_search (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [stbs_pkg::CNT_W-1:0] cfg_wr_data,
	stbs_in_if.sink                    in_ch,
	stbs_out_if.source                 out_ch
);

	localparam int BW = stbs_pkg::BOUND_W;

	logic [stbs_pkg::CNT_W-1:0] entry_count_q;
	logic [BW-1:0]              count_sat;
	stbs_pkg::ram_req_t         ram_req;
	logic [stbs_pkg::KEY_W-1:0] ram_rdata;

	// Entry count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_wr_en) begin
			entry_count_q <= cfg_wr_data;
		end
	end

	// A count beyond the table depth searches the whole table.
	always_comb begin
		if ({{(32 - stbs_pkg::CNT_W){1'b0}}, entry_count_q} > 32'(stbs_pkg::TABLE_DEPTH)) begin
			count_sat = BW'(stbs_pkg::TABLE_DEPTH);
		end else begin
			count_sat = BW'(entry_count_q);
		end
	end

	// Key memory.
	stbs_ram #(
		.WIDTH(stbs_pkg::KEY_W),
		.DEPTH(stbs_pkg::TABLE_DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.addr  (ram_req.addr),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

	// Search sequencer.
	stbs_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.count     (count_sat),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

endmodule
